// ----- hdl/nearest_first_request_table_macros.svh -----
// Assertion macros for the request table.
// NFRT_ASSERT_IMP checks an overlapped implication, NFRT_ASSERT_NXT a next-cycle one.
`ifndef NEAREST_FIRST_REQUEST_TABLE_MACROS_SVH
`define NEAREST_FIRST_REQUEST_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define NFRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define NFRT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NFRT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define NFRT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/nfrt_pkg.sv -----
`timescale 1ns / 1ps

package nfrt_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int BLOCK_EDGE  = 16;
   localparam int COORD_BITS  = 16;

   localparam int FIELD_W   = 16;
   localparam int TARGET_W  = 24;
   localparam int STATUS_W  = 3;
   localparam int PEND_W    = 5;
   localparam int REQ_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CTR_W  = COORD_BITS + $clog2(2 * BLOCK_EDGE) + 2;
   localparam int DIFF_W = ((CTR_W > TARGET_W) ? CTR_W : TARGET_W) + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int EXT_W  = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

   localparam logic signed [CTR_W-1:0] EDGE2 = CTR_W'(2 * BLOCK_EDGE);
   localparam logic signed [CTR_W-1:0] HALF2 = CTR_W'(2 * (BLOCK_EDGE / 2));

   localparam logic [REQ_W-1:0] REQ_INSERT    = 2'd0;
   localparam int               REQ_CLEAR_BIT = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Z = 2'd2;

   localparam logic [2:0] PH_READ  = 3'd0;
   localparam logic [2:0] PH_MAG_X = 3'd1;
   localparam logic [2:0] PH_MAG_Y = 3'd2;
   localparam logic [2:0] PH_MAG_Z = 3'd3;
   localparam logic [2:0] PH_ADD_Y = 3'd4;
   localparam logic [2:0] PH_ADD_Z = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      RSP_ACCEPTED  = 3'd0,
      RSP_DUPLICATE = 3'd1,
      RSP_FULL      = 3'd2,
      RSP_GRANTED   = 3'd3,
      RSP_EMPTY     = 3'd4,
      RSP_CLEARED   = 3'd5
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DUP,
      S_INSERT,
      S_DIST,
      S_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } coord_set_type;

   function automatic logic signed [COORD_BITS-1:0] coord_from_field(
      input logic [FIELD_W-1:0] f);
      logic [EXT_W-1:0] raw;
      raw = EXT_W'(f);
      return raw[COORD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] coord_to_field(
      input logic signed [COORD_BITS-1:0] c);
      logic signed [EXT_W-1:0] wide;
      wide = EXT_W'(c);
      return wide[FIELD_W-1:0];
   endfunction

   // distance from doubled block center to target along one axis
   function automatic logic [DIFF_W-1:0] axis_mag(
      input logic signed [COORD_BITS-1:0] c,
      input logic signed [TARGET_W-1:0]   t);
      logic signed [CTR_W-1:0]  ctr;
      logic signed [DIFF_W-1:0] diff;
      ctr  = CTR_W'(c) * EDGE2 + HALF2;
      diff = DIFF_W'(ctr) - DIFF_W'(t);
      return diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   endfunction

endpackage

// ----- hdl/nearest_first_request_table.sv -----
`timescale 1ns / 1ps
// Channel   Dir   Handshake              Word
// req       in    req_valid/req_ready    req_type, req_coord_x/y/z
// rsp       out   rsp_valid/rsp_ready    rsp_status, rsp_out_x/y/z, rsp_pending_count
// csr       in    csr_we                 csr_index, csr_wdata
//
// One request word at a time; req_ready is high only while the sequencer is idle.
// Clear or empty take go straight to the response. Insert: duplicate scan, one entry
// per cycle through the table's registered read port, then the write if not full.
// Take: each pending entry passes through six phases that share one squaring
// multiplier across its axes, then each entry behind the grant at k is read and written one place down.
// A waiting response word stalls only the finish of the next request.
// Synchronous reset empties the table and clears the target; no clearing pass.

`include "nearest_first_request_table_macros.svh"

module nearest_first_request_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [nfrt_pkg::REQ_W-1:0]       req_type,
   input  logic signed [nfrt_pkg::FIELD_W-1:0] req_coord_x,
   input  logic signed [nfrt_pkg::FIELD_W-1:0] req_coord_y,
   input  logic signed [nfrt_pkg::FIELD_W-1:0] req_coord_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [nfrt_pkg::STATUS_W-1:0]    rsp_status,
   output logic signed [nfrt_pkg::FIELD_W-1:0] rsp_out_x,
   output logic signed [nfrt_pkg::FIELD_W-1:0] rsp_out_y,
   output logic signed [nfrt_pkg::FIELD_W-1:0] rsp_out_z,
   output logic [nfrt_pkg::PEND_W-1:0]      rsp_pending_count,
   input  logic                             csr_we,
   input  logic [nfrt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nfrt_pkg::TARGET_W-1:0]    csr_wdata
);
   import nfrt_pkg::*;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           total_ff, total_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic                       pend_ff, pend_in;
   logic [2:0]                 ph_ff, ph_in;
   logic                       wr_ph_ff, wr_ph_in;
   rsp_status_type             status_ff, status_in;
   logic [CNT_W-1:0]           best_idx_ff, best_idx_in;
   logic [SUM_W-1:0]           best_d_ff, best_d_in;
   coord_set_type              best_ff, best_in;
   logic [SUM_W-1:0]           acc_ff, acc_in;
   logic [DIFF_W-1:0]          mag_ff, mag_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   coord_set_type              new_ff;
   logic signed [TARGET_W-1:0] tgt_x_ff, tgt_y_ff, tgt_z_ff;

   coord_set_type              mem [QUEUE_DEPTH];
   coord_set_type              rd_data_ff;
   logic [IDX_W-1:0]           rd_addr;
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_wa;
   coord_set_type              mem_wd;

   logic                       rsp_valid_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;
   logic [FIELD_W-1:0]         rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [PEND_W-1:0]          rsp_count_ff;
   logic                       rsp_load;

   logic                       req_accept;
   logic                       is_clear, is_insert;
   logic [CNT_W-1:0]           idx_next;
   logic                       dup_issue, dup_match;
   logic [SUM_W-1:0]           dist_sum;
   logic                       dist_better, dist_last;
   logic                       shift_more, resp_free;
   logic signed [COORD_BITS-1:0] axis_coord;
   logic signed [TARGET_W-1:0] axis_tgt;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign is_clear    = req_type[REQ_CLEAR_BIT];
   assign is_insert   = (req_type == REQ_INSERT);
   assign idx_next    = idx_ff + CNT_W'(1);
   assign dup_issue   = (idx_ff < total_ff);
   assign dup_match   = pend_ff && (rd_data_ff == new_ff);
   assign dist_sum    = acc_ff + SUM_W'(sq_ff);
   assign dist_better = (idx_ff == '0) || (dist_sum < best_d_ff);
   assign dist_last   = (idx_next == total_ff);
   assign shift_more  = (idx_next < total_ff);
   assign resp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (ph_ff)
         PH_MAG_X: begin
            axis_coord = rd_data_ff.x;
            axis_tgt   = tgt_x_ff;
         end
         PH_MAG_Y: begin
            axis_coord = rd_data_ff.y;
            axis_tgt   = tgt_y_ff;
         end
         default: begin
            axis_coord = rd_data_ff.z;
            axis_tgt   = tgt_z_ff;
         end
      endcase
   end

   assign mag_in = axis_mag(axis_coord, axis_tgt);
   assign sq_in  = mag_ff * mag_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (is_clear) state_in = S_RESP;
               else if (is_insert) state_in = S_DUP;
               else if (total_ff == '0) state_in = S_RESP;
               else state_in = S_DIST;
            end
         end
         S_DUP: begin
            if (dup_match) state_in = S_RESP;
            else if (!dup_issue) state_in = S_INSERT;
         end
         S_INSERT: state_in = S_RESP;
         S_DIST: begin
            if (ph_ff == PH_ADD_Z && dist_last) state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (!shift_more) state_in = S_RESP;
         end
         S_RESP: begin
            if (resp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      total_in    = total_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      ph_in       = ph_ff;
      wr_ph_in    = wr_ph_ff;
      status_in   = status_ff;
      best_idx_in = best_idx_ff;
      best_d_in   = best_d_ff;
      best_in     = best_ff;
      acc_in      = acc_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      mem_we      = 1'b0;
      mem_wa      = idx_ff[IDX_W-1:0];
      mem_wd      = rd_data_ff;
      rsp_load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               idx_in   = '0;
               pend_in  = 1'b0;
               ph_in    = PH_READ;
               wr_ph_in = 1'b0;
               if (is_clear) begin
                  total_in  = '0;
                  status_in = RSP_CLEARED;
               end else if (!is_insert && total_ff == '0) begin
                  status_in = RSP_EMPTY;
               end
            end
         end
         S_DUP: begin
            pend_in = dup_issue;
            if (dup_match) begin
               status_in = RSP_DUPLICATE;
            end else if (dup_issue) begin
               idx_in = idx_next;
            end
         end
         S_INSERT: begin
            if (total_ff >= CNT_W'(QUEUE_DEPTH)) begin
               status_in = RSP_FULL;
            end else begin
               mem_we    = 1'b1;
               mem_wa    = total_ff[IDX_W-1:0];
               mem_wd    = new_ff;
               total_in  = total_ff + CNT_W'(1);
               status_in = RSP_ACCEPTED;
            end
         end
         S_DIST: begin
            if (ph_ff == PH_MAG_Z) acc_in = SUM_W'(sq_ff);
            if (ph_ff == PH_ADD_Y) acc_in = dist_sum;
            if (ph_ff == PH_ADD_Z) begin
               ph_in = PH_READ;
               if (dist_better) begin
                  best_d_in   = dist_sum;
                  best_idx_in = idx_ff;
                  best_in     = rd_data_ff;
               end
               if (dist_last) begin
                  idx_in    = dist_better ? idx_ff : best_idx_ff;
                  status_in = RSP_GRANTED;
               end else begin
                  idx_in = idx_next;
               end
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         S_SHIFT: begin
            rd_addr = idx_next[IDX_W-1:0];
            if (!shift_more) begin
               total_in = total_ff - CNT_W'(1);
            end else if (!wr_ph_ff) begin
               wr_ph_in = 1'b1;
            end else begin
               mem_we   = 1'b1;
               idx_in   = idx_next;
               wr_ph_in = 1'b0;
            end
         end
         S_RESP: rsp_load = resp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         ph_ff    <= PH_READ;
         wr_ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         ph_ff    <= ph_in;
         wr_ph_ff <= wr_ph_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      best_idx_ff <= best_idx_in;
      best_d_ff   <= best_d_in;
      best_ff     <= best_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      sq_ff       <= sq_in;
      if (req_accept) begin
         new_ff.x <= coord_from_field(req_coord_x);
         new_ff.y <= coord_from_field(req_coord_y);
         new_ff.z <= coord_from_field(req_coord_z);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_x_ff <= '0;
         tgt_y_ff <= '0;
         tgt_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_X: tgt_x_ff <= csr_wdata;
            CSR_TARGET_Y: tgt_y_ff <= csr_wdata;
            CSR_TARGET_Z: tgt_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= PEND_W'(total_ff);
         if (status_ff == RSP_GRANTED) begin
            rsp_x_ff <= coord_to_field(best_ff.x);
            rsp_y_ff <= coord_to_field(best_ff.y);
            rsp_z_ff <= coord_to_field(best_ff.z);
         end else begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
            rsp_z_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_z         = rsp_z_ff;
   assign rsp_pending_count = rsp_count_ff;

   `NFRT_ASSERT_IMP(a_total_bound, clock, reset, 1'b1, total_ff <= CNT_W'(QUEUE_DEPTH), "pending total beyond table depth")
   `NFRT_ASSERT_IMP(a_zero_unless_granted, clock, reset, rsp_valid && rsp_status != RSP_GRANTED, rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0, "coordinates on a non-grant word")
   `NFRT_ASSERT_IMP(a_clear_empties, clock, reset, rsp_valid && rsp_status == RSP_CLEARED, rsp_pending_count == '0, "clear left entries pending")
   `NFRT_ASSERT_IMP(a_take_nonempty, clock, reset, state_ff == S_DIST || state_ff == S_SHIFT, total_ff != '0, "take scan on an empty table")
   `NFRT_ASSERT_NXT(a_insert_grows, clock, reset, state_ff == S_INSERT && total_ff < CNT_W'(QUEUE_DEPTH), total_ff == $past(total_ff) + CNT_W'(1), "insert did not add an entry")

endmodule

// ----- tb/sv/nearest_first_request_table_test.sv -----
`timescale 1ns / 1ps

module nearest_first_request_table_test;
   import nfrt_pkg::*;

   localparam logic [REQ_W-1:0] REQ_TAKE        = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR       = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR_ALIAS = 2'd3;

   localparam int IDLE_PCT     = 7;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 135;
   localparam int DRAIN_CYCLES = 140;
   localparam int CYCLE_LIMIT  = 800000;

   typedef struct {
      logic [REQ_W-1:0]   kind;
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] z;
      bit                 hold_for_drain;
   } request_word_type;

   typedef struct {
      rsp_status_type     status;
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] z;
      logic [PEND_W-1:0]  count;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [REQ_W-1:0]    req_type = REQ_INSERT;
   logic [FIELD_W-1:0]  req_coord_x = '0;
   logic [FIELD_W-1:0]  req_coord_y = '0;
   logic [FIELD_W-1:0]  req_coord_z = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [FIELD_W-1:0]  rsp_out_x;
   logic [FIELD_W-1:0]  rsp_out_y;
   logic [FIELD_W-1:0]  rsp_out_z;
   logic [PEND_W-1:0]   rsp_pending_count;
   logic                csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TARGET_X;
   logic [TARGET_W-1:0] csr_wdata = '0;

   coord_set_type               pending_blocks[QUEUE_DEPTH];
   int                          pending_total = 0;
   logic signed [TARGET_W-1:0]  aim_x = '0;
   logic signed [TARGET_W-1:0]  aim_y = '0;
   logic signed [TARGET_W-1:0]  aim_z = '0;

   request_word_type words_to_send[$];
   request_word_type on_wire;
   answer_type       answers_due[$];
   answer_type       want;
   int            n_sent = 0;
   int            n_done = 0;
   int            mismatches = 0;
   int            cycle_count = 0;
   int            settings_used = 1;
   int            tally[6] = '{default: 0};
   bit            calm = 1'b0;

   nearest_first_request_table DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_pending_count(rsp_pending_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint axis_gap_sq(input logic signed [COORD_BITS-1:0] c,
                                          input logic signed [TARGET_W-1:0] t);
      longint d;
      d = longint'(c) * (2 * BLOCK_EDGE) + 2 * (BLOCK_EDGE / 2) - longint'(t);
      return d * d;
   endfunction

   function automatic answer_type table_answer(input request_word_type w);
      answer_type    a;
      coord_set_type c;
      longint        gap_sum;
      longint        best_dist;
      int            best;
      int            i;
      a.status = RSP_CLEARED;
      a.x = '0;
      a.y = '0;
      a.z = '0;
      c.x = w.x[COORD_BITS-1:0];
      c.y = w.y[COORD_BITS-1:0];
      c.z = w.z[COORD_BITS-1:0];
      best = 0;
      best_dist = 0;
      if (w.kind[REQ_CLEAR_BIT]) begin
         pending_total = 0;
      end else if (w.kind == REQ_INSERT) begin
         a.status = RSP_ACCEPTED;
         for (i = 0; i < pending_total; i++) begin
            if (pending_blocks[i] == c) a.status = RSP_DUPLICATE;
         end
         if (a.status == RSP_ACCEPTED) begin
            if (pending_total >= QUEUE_DEPTH) begin
               a.status = RSP_FULL;
            end else begin
               pending_blocks[pending_total] = c;
               pending_total++;
            end
         end
      end else if (pending_total == 0) begin
         a.status = RSP_EMPTY;
      end else begin
         for (i = 0; i < pending_total; i++) begin
            gap_sum = axis_gap_sq(pending_blocks[i].x, aim_x) +
                      axis_gap_sq(pending_blocks[i].y, aim_y) +
                      axis_gap_sq(pending_blocks[i].z, aim_z);
            if (i == 0 || gap_sum < best_dist) begin
               best_dist = gap_sum;
               best = i;
            end
         end
         a.status = RSP_GRANTED;
         a.x = FIELD_W'(pending_blocks[best].x);
         a.y = FIELD_W'(pending_blocks[best].y);
         a.z = FIELD_W'(pending_blocks[best].z);
         for (i = best; i + 1 < pending_total; i++) begin
            pending_blocks[i] = pending_blocks[i + 1];
         end
         pending_total--;
      end
      a.count = PEND_W'(pending_total);
      tally[a.status]++;
      return a;
   endfunction

   function automatic void note_miss(input string what, input longint want_v,
                                     input longint got_v);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch in %s of response %0d: expected %0d, got %0d",
                  what, n_done, want_v, got_v);
      end
   endfunction

   function automatic void add_request(input logic [REQ_W-1:0] kind,
                                       input logic [FIELD_W-1:0] x,
                                       input logic [FIELD_W-1:0] y,
                                       input logic [FIELD_W-1:0] z,
                                       input bit hold_for_drain = 1'b0);
      request_word_type w;
      w.kind = kind;
      w.x = x;
      w.y = y;
      w.z = z;
      w.hold_for_drain = hold_for_drain;
      words_to_send = {words_to_send, w};
   endfunction

   function automatic logic [FIELD_W-1:0] pick_coord(input int spot);
      int r;
      r = $urandom_range(99);
      if (r < 45) return FIELD_W'(spot + int'($urandom_range(6)) - 3);
      if (r < 55) return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
      return FIELD_W'($urandom);
   endfunction

   task automatic settle();
      do @(negedge clock);
      while (words_to_send.size() != 0 || req_valid || n_sent != n_done);
   endtask

   task automatic set_aim(input logic [TARGET_W-1:0] tx,
                          input logic [TARGET_W-1:0] ty,
                          input logic [TARGET_W-1:0] tz);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET_X;
      csr_wdata <= tx;
      @(posedge clock);
      csr_index <= CSR_TARGET_Y;
      csr_wdata <= ty;
      @(posedge clock);
      csr_index <= CSR_TARGET_Z;
      csr_wdata <= tz;
      @(posedge clock);
      csr_we <= 1'b0;
      aim_x = tx;
      aim_y = ty;
      aim_z = tz;
      settings_used++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, answers_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            answers_due = {answers_due, table_answer(on_wire)};
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (words_to_send.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
                (!words_to_send[0].hold_for_drain || n_sent == n_done)) begin
               on_wire = words_to_send.pop_front();
               req_valid   <= 1'b1;
               req_type    <= on_wire.kind;
               req_coord_x <= on_wire.x;
               req_coord_y <= on_wire.y;
               req_coord_z <= on_wire.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_done <= n_done + 1;
            if (answers_due.size() == 0) begin
               note_miss("unexpected response status", -1, rsp_status);
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status)
                  note_miss("status", want.status, rsp_status);
               if (rsp_out_x !== want.x)
                  note_miss("out_x", $signed(want.x), $signed(rsp_out_x));
               if (rsp_out_y !== want.y)
                  note_miss("out_y", $signed(want.y), $signed(rsp_out_y));
               if (rsp_out_z !== want.z)
                  note_miss("out_z", $signed(want.z), $signed(rsp_out_z));
               if (rsp_pending_count !== want.count)
                  note_miss("pending_count", want.count, rsp_pending_count);
            end
         end
         rsp_ready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   initial begin
      int phase;
      int n;
      int i;
      int spot;
      int r;
      int insert_pct;
      logic [REQ_W-1:0] kind;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // target at origin: empty take, ties, extremes, full table, both clear codes
      add_request(REQ_TAKE, 16'h1234, 16'hFEDC, 16'h0001);
      add_request(REQ_INSERT, 16'h0000, 16'h0000, 16'h0000);
      add_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_request(REQ_INSERT, 16'h0000, 16'h0000, 16'h0000);
      add_request(REQ_TAKE, 16'hFFFF, 16'h0000, 16'hFFFF);
      add_request(REQ_INSERT, 16'h8000, 16'h8000, 16'h8000);
      add_request(REQ_INSERT, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      add_request(REQ_INSERT, 16'h0001, 16'hFFFE, 16'h0003);
      for (i = 2; i < 14; i++) begin
         add_request(REQ_INSERT, FIELD_W'(i), FIELD_W'(-i), FIELD_W'(2 * i));
      end
      add_request(REQ_INSERT, 16'h5555, 16'hAAAA, 16'h0F0F);
      add_request(REQ_INSERT, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      add_request(REQ_TAKE, 16'h0000, 16'h0000, 16'h0000);
      add_request(REQ_CLEAR_ALIAS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      add_request(REQ_TAKE, 16'h0000, 16'h0000, 16'h0000);
      add_request(REQ_INSERT, 16'h8000, 16'h7FFF, 16'h0000);
      add_request(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);
      settle();

      for (phase = 1; phase <= PHASES; phase++) begin
         spot = int'($urandom_range(80)) - 40;
         case (phase)
            1: set_aim(24'h7FFFFF, 24'h800000, 24'h000000);
            2: set_aim(24'h800000, 24'h800000, 24'h800000);
            3: set_aim(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
            4: set_aim(TARGET_W'($urandom), TARGET_W'($urandom), TARGET_W'($urandom));
            default: set_aim(TARGET_W'(32 * spot + 16 * int'($urandom_range(1))),
                             TARGET_W'(32 * spot), TARGET_W'(32 * spot + 16));
         endcase
         calm = (phase == 5);
         insert_pct = (phase % 3 == 0) ? 65 : ((phase % 3 == 1) ? 50 : 45);
         for (n = 0; n < PHASE_WORDS; n++) begin
            r = $urandom_range(99);
            if (r < 4) kind = ($urandom_range(1) != 0) ? REQ_CLEAR : REQ_CLEAR_ALIAS;
            else if (r < 4 + insert_pct) kind = REQ_INSERT;
            else kind = REQ_TAKE;
            add_request(kind, pick_coord(spot), pick_coord(spot), pick_coord(spot),
                        n == PHASE_WORDS / 2);
         end
         settle();
      end
      calm = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests under %0d target settings: %0d accepted, %0d duplicates,",
               n_sent, settings_used, tally[RSP_ACCEPTED], tally[RSP_DUPLICATE]);
      $display("%0d full drops, %0d grants, %0d empty takes, %0d clears; %0d mismatches",
               tally[RSP_FULL], tally[RSP_GRANTED], tally[RSP_EMPTY], tally[RSP_CLEARED],
               mismatches);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- nearest_first_request_table.f -----
+incdir+hdl
hdl/nfrt_pkg.sv
hdl/nearest_first_request_table.sv
tb/sv/nearest_first_request_table_test.sv
